// ----- rtl/ffcd_pkg.sv -----
// Shared types and constants for the feedback frame change detector.
`timescale 1ns / 1ps

package ffcd_pkg;

  localparam int unsigned MAX_FEEDBACK_BYTES_DEF = 64;
  localparam logic [7:0]  HEADER_BYTE            = 8'h69;
  localparam int unsigned CONTACT_W              = 10;
  localparam int unsigned OUT_DATA_W             = 16;
  localparam int unsigned IN_DATA_W              = 8;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_COUNT  = 3'd1,
    PH_MODULE = 3'd2,
    PH_HIGH   = 3'd3,
    PH_LOW    = 3'd4,
    PH_TRAIL  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_LO,
    S_RD_HI,
    S_CMP,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic take;
    logic rd_sel;
    logic cap_lo;
    logic cap_hi;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rec_hit;
    logic mask_nz;
    logic last;
  } dp_status_t;

endpackage

// ----- rtl/ffcd_ctrl.sv -----
// Controller state machine: byte intake, store read sequence and event emission.
`timescale 1ns / 1ps

module ffcd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ffcd_pkg::dp_status_t status,
  output ffcd_pkg::ctrl_cmd_t  cmd
);
  import ffcd_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && status.rec_hit) begin
          state_next = S_RD_LO;
        end
      end
      S_RD_LO: state_next = S_RD_HI;
      S_RD_HI: state_next = S_CMP;
      S_CMP:   state_next = S_EMIT;
      S_EMIT: begin
        if (!status.mask_nz || (out_ready && status.last)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_RD_LO: cmd.rd_sel = 1'b0;
      S_RD_HI: begin
        cmd.rd_sel = 1'b1;
        cmd.cap_lo = 1'b1;
      end
      S_CMP: cmd.cap_hi = 1'b1;
      S_EMIT: begin
        out_valid = status.mask_nz;
        cmd.pop   = status.mask_nz && out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/ffcd_datapath.sv -----
// Datapath: frame parser registers, feedback byte store, change mask and event encoder.
`timescale 1ns / 1ps

module ffcd_datapath #(
  parameter int unsigned MAX_FEEDBACK_BYTES = ffcd_pkg::MAX_FEEDBACK_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [ffcd_pkg::IN_DATA_W-1:0]        rx_byte,
  input  ffcd_pkg::ctrl_cmd_t                   cmd,
  output ffcd_pkg::dp_status_t                  status,
  output logic [ffcd_pkg::CONTACT_W-1:0]        contact,
  output logic                                  occupied
);
  import ffcd_pkg::*;

  localparam int unsigned AW   = (MAX_FEEDBACK_BYTES > 2) ? $clog2(MAX_FEEDBACK_BYTES) : 1;
  localparam logic [7:0]  HALF = 8'(MAX_FEEDBACK_BYTES >> 1);

  phase_t     phase;
  logic [7:0] records_left;
  logic [7:0] record_module;
  logic [7:0] held_high_byte;
  logic [7:0] low_byte;
  logic [7:0] left_dec;

  logic [7:0]    mem [MAX_FEEDBACK_BYTES];
  logic [7:0]    rdata;
  logic [MAX_FEEDBACK_BYTES-1:0] first_report;
  logic [8:0]    pos_full;
  logic [AW-1:0] pos;
  logic [AW-1:0] pos_hi;
  logic [AW-1:0] rd_addr;
  logic [15:0]   mask;
  logic [7:0]    diff;
  logic [3:0]    idx;
  logic [15:0]   rest;
  logic [15:0]   val16;
  logic [15:0]   contact_full;

  assign left_dec = records_left - 8'd1;
  assign pos_full = {1'b0, record_module - 8'd1} << 1;
  assign pos      = pos_full[AW-1:0];
  assign pos_hi   = pos + AW'(1);
  assign rd_addr  = cmd.rd_sel ? pos_hi : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      records_left   <= '0;
      record_module  <= '0;
      held_high_byte <= '0;
    end else if (cmd.take) begin
      case (phase)
        PH_COUNT: begin
          records_left <= rx_byte;
          phase        <= (rx_byte == 8'd0) ? PH_TRAIL : PH_MODULE;
        end
        PH_MODULE: begin
          record_module <= rx_byte;
          phase         <= PH_HIGH;
        end
        PH_HIGH: begin
          held_high_byte <= rx_byte;
          phase          <= PH_LOW;
        end
        PH_LOW: begin
          records_left <= left_dec;
          phase        <= (left_dec == 8'd0) ? PH_TRAIL : PH_MODULE;
        end
        PH_TRAIL: phase <= PH_HUNT;
        default: phase <= (rx_byte == HEADER_BYTE) ? PH_COUNT : PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      low_byte <= rx_byte;
    end
  end

  assign status.rec_hit = (phase == PH_LOW) && (record_module != 8'd0) &&
                          (record_module <= HALF);

  always_ff @(posedge clk) begin
    if (cmd.cap_lo) begin
      mem[pos] <= low_byte;
    end else if (cmd.cap_hi) begin
      mem[pos_hi] <= held_high_byte;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    if (cmd.cap_lo) begin
      diff = first_report[pos] ? 8'hFF : (rdata ^ low_byte);
    end else begin
      diff = first_report[pos_hi] ? 8'hFF : (rdata ^ held_high_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_report <= '1;
    end else if (cmd.cap_hi) begin
      first_report[pos]    <= 1'b0;
      first_report[pos_hi] <= 1'b0;
    end
  end

  always_comb begin
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (mask[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign rest = mask & ~(16'd1 << idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.cap_lo) begin
      mask[7:0] <= diff;
    end else if (cmd.cap_hi) begin
      mask[15:8] <= diff;
    end else if (cmd.pop) begin
      mask <= rest;
    end
  end

  assign status.mask_nz = (mask != 16'd0);
  assign status.last    = (rest == 16'd0);

  assign val16        = {held_high_byte, low_byte};
  assign contact_full = (16'(pos) << 3) + 16'(idx) + 16'd1;
  assign contact      = contact_full[CONTACT_W-1:0];
  assign occupied     = val16[idx];

endmodule

// ----- rtl/feedback_frame_change_detector_core.sv -----
// Top level of the feedback frame change detector.
//
// Slave channel s_axis_*: one received serial byte per word in tdata[7:0].
// Master channel m_axis_*: one contact event per word, tdata holds the
// contact number and its new state, tlast marks the final event of a record.
// Bytes that do not complete a record are taken one per cycle while no
// lookup is pending, and give no events. The low byte of a record triggers
// a store lookup: both stored positions are read in turn through the
// single-read-port byte store in S_RD_LO, S_RD_HI and S_CMP, m_axis_tvalid
// rises in S_EMIT, and events then follow one per cycle while m_axis_tready
// is high, up to sixteen per record. A record with no changes goes from
// S_EMIT straight back to S_IDLE and raises s_axis_tready again.
// s_axis_tready stays low while a record is being compared or its events
// are pending.
// Reset clears the parser to header hunt and marks every position as not
// yet reported at once; no clearing pass is needed.
// When the receiver stalls, the current event holds on m_axis_tdata and
// m_axis_tlast until taken, and no further byte is accepted.
`timescale 1ns / 1ps

module feedback_frame_change_detector_core #(
  parameter int unsigned MAX_FEEDBACK_BYTES = ffcd_pkg::MAX_FEEDBACK_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [ffcd_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // [7:0] rx_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [ffcd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [9:0] contact, [10] occupied
  output logic                               m_axis_tlast    // last_event
);
  import ffcd_pkg::*;

  ctrl_cmd_t                cmd;
  dp_status_t               status;
  logic [CONTACT_W-1:0]     contact;
  logic                     occupied;

  ffcd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ffcd_datapath #(
    .MAX_FEEDBACK_BYTES (MAX_FEEDBACK_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (s_axis_tdata),
    .cmd      (cmd),
    .status   (status),
    .contact  (contact),
    .occupied (occupied)
  );

  assign m_axis_tdata = {(OUT_DATA_W - CONTACT_W - 1)'(0), occupied, contact};
  assign m_axis_tlast = status.last;

endmodule

// ----- rtl/ffcd_checker.sv -----
// Port-level assertions for the feedback frame change detector, bound to the top level.
`timescale 1ns / 1ps

module ffcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled event word changed");

  a_no_intake_while_emitting: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("byte intake open while events pending");

  a_contact_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[9:0] != 10'd0) && (m_axis_tdata[15:11] == 5'd0))
    else $error("event word out of range");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("not idle after reset");

  a_no_event_after_plain_byte: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("event without store lookup");

endmodule

bind feedback_frame_change_detector_core ffcd_checker u_ffcd_checker (.*);

// ----- sim/feedback_frame_change_detector_core_test.sv -----
// Self-checking stream testbench for the feedback frame change detector core.
`timescale 1ns / 1ps

module feedback_frame_change_detector_core_test;
  import ffcd_pkg::*;

  localparam int unsigned STORE_BYTES = MAX_FEEDBACK_BYTES_DEF;
  localparam int RANDOM_BYTES = 280;
  localparam int CALM_TAIL = 40;
  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [CONTACT_W-1:0] contact;
    logic                 occupied;
    logic                 last_event;
  } contact_change_t;

  typedef struct {
    logic [7:0] value;
    bit         wait_drain;
  } rx_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  feedback_frame_change_detector_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  rx_word_t        tx_bytes[$];
  contact_change_t pending_changes[$];
  logic [7:0]      gen_store [STORE_BYTES];

  logic [7:0]      seen_bytes [STORE_BYTES];
  bit              unseen [STORE_BYTES];
  phase_t          parse_ph;
  logic [7:0]      recs_left;
  logic [7:0]      rec_module;
  logic [7:0]      held_hi;
  contact_change_t batch [16];
  int              batch_n;

  bit byte_taken = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int quiet_cycles = 0;
  int errors = 0;
  int bytes_fed = 0;
  int events_checked = 0;
  int frames_seen = 0;
  int records_skipped = 0;
  int records_done = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void note_position_change(input int unsigned pos, input logic [7:0] val);
    logic [7:0] diff;
    diff = unseen[pos] ? 8'hFF : (seen_bytes[pos] ^ val);
    if (diff != 8'h00) begin
      for (int b = 0; b < 8; b++) begin
        if (diff[b]) begin
          batch[batch_n] = '{contact: CONTACT_W'(pos * 8 + b + 1), occupied: val[b],
                             last_event: 1'b0};
          batch_n++;
        end
      end
      seen_bytes[pos] = val;
      unseen[pos] = 1'b0;
    end
  endfunction

  function automatic void absorb_rx_byte(input logic [7:0] b);
    int unsigned pos;
    contact_change_t c;
    batch_n = 0;
    case (parse_ph)
      PH_COUNT: begin
        recs_left = b;
        parse_ph = (b == 8'd0) ? PH_TRAIL : PH_MODULE;
      end
      PH_MODULE: begin
        rec_module = b;
        parse_ph = PH_HIGH;
      end
      PH_HIGH: begin
        held_hi = b;
        parse_ph = PH_LOW;
      end
      PH_LOW: begin
        if (rec_module != 8'd0 && rec_module <= STORE_BYTES / 2) begin
          pos = (rec_module - 1) * 2;
          note_position_change(pos, b);
          note_position_change(pos + 1, held_hi);
        end else begin
          records_skipped++;
        end
        records_done++;
        recs_left = recs_left - 8'd1;
        parse_ph = (recs_left == 8'd0) ? PH_TRAIL : PH_MODULE;
      end
      PH_TRAIL: begin
        parse_ph = PH_HUNT;
      end
      default: begin
        if (b == HEADER_BYTE) begin
          parse_ph = PH_COUNT;
          frames_seen++;
        end else begin
          parse_ph = PH_HUNT;
        end
      end
    endcase
    for (int i = 0; i < batch_n; i++) begin
      c = batch[i];
      c.last_event = (i == batch_n - 1);
      pending_changes.push_back(c);
    end
  endfunction

  function automatic void send_word(input logic [7:0] value, input bit wait_drain);
    rx_word_t w;
    w.value = value;
    w.wait_drain = wait_drain;
    tx_bytes.push_back(w);
  endfunction

  function automatic void send_record(input logic [7:0] m, input logic [7:0] hi,
                                      input logic [7:0] lo);
    send_word(m, 1'b0);
    send_word(hi, 1'b0);
    send_word(lo, 1'b0);
    if (m != 8'd0 && m <= STORE_BYTES / 2) begin
      gen_store[(m - 1) * 2] = lo;
      gen_store[(m - 1) * 2 + 1] = hi;
    end
  endfunction

  function automatic logic [7:0] pick_byte(input int unsigned pos);
    int r;
    logic [7:0] v;
    r = $urandom_range(0, 9);
    v = gen_store[pos];
    if (r < 5) begin
      v[$urandom_range(0, 7)] ^= 1'b1;
      if (r < 2) v[$urandom_range(0, 7)] ^= 1'b1;
    end else if (r >= 7) begin
      v = 8'($urandom_range(0, 255));
    end
    return v;
  endfunction

  always @(posedge clk) begin
    contact_change_t want;
    if (rst) begin
      for (int i = 0; i < STORE_BYTES; i++) begin
        seen_bytes[i] = 8'h00;
        unseen[i] = 1'b1;
      end
      parse_ph = PH_HUNT;
      recs_left = 8'd0;
      rec_module = 8'd0;
      held_hi = 8'd0;
      quiet_cycles = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_rx_byte(s_axis_tdata);
        byte_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_changes.size() == 0) begin
          report_mismatch($sformatf("unexpected event contact %0d occupied %0b",
                                    m_axis_tdata[CONTACT_W-1:0], m_axis_tdata[CONTACT_W]));
        end else begin
          want = pending_changes.pop_front();
          events_checked++;
          if (m_axis_tdata[CONTACT_W-1:0] !== want.contact)
            report_mismatch($sformatf("contact %0d, want %0d",
                                      m_axis_tdata[CONTACT_W-1:0], want.contact));
          if (m_axis_tdata[CONTACT_W] !== want.occupied)
            report_mismatch($sformatf("contact %0d occupied %0b, want %0b", want.contact,
                                      m_axis_tdata[CONTACT_W], want.occupied));
          if (m_axis_tlast !== want.last_event)
            report_mismatch($sformatf("contact %0d tlast %0b, want %0b", want.contact,
                                      m_axis_tlast, want.last_event));
          if (m_axis_tdata[OUT_DATA_W-1:CONTACT_W+1] !== '0)
            report_mismatch($sformatf("contact %0d padding bits set: %h", want.contact,
                                      m_axis_tdata));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("stalled for %0d cycles with %0d bytes and %0d events outstanding",
                 quiet_cycles, tx_bytes.size(), pending_changes.size());
        $display("feedback_frame_change_detector_core verification failed");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    logic       nv;
    logic [7:0] nd;
    bit         taken;
    bit         calm;
    nv = 1'b0;
    nd = s_axis_tdata;
    if (!rst) begin
      taken = byte_taken;
      byte_taken = 1'b0;
      if (taken) begin
        void'(tx_bytes.pop_front());
        bytes_fed++;
      end
      calm = tx_bytes.size() < CALM_TAIL;
      if (s_axis_tvalid && !taken) begin
        nv = 1'b1;
      end else if (tx_gap > 0) begin
        tx_gap--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(1, 17) - 1;
      end else if (tx_bytes.size() != 0 &&
                   !(tx_bytes[0].wait_drain && pending_changes.size() != 0)) begin
        nv = 1'b1;
        nd = tx_bytes[0].value;
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  always @(negedge clk) begin
    logic nr;
    nr = 1'b0;
    if (!rst) begin
      if (rx_gap > 0) begin
        rx_gap--;
      end else if (tx_bytes.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
        rx_gap = $urandom_range(1, 17) - 1;
      end else begin
        nr = 1'b1;
      end
    end
    m_axis_tready <= nr;
  end

  initial begin
    int fed;
    int kind;
    int count;
    int n;
    int m;
    bit first_frame;
    logic [7:0] noise;
    for (int i = 0; i < STORE_BYTES; i++) gen_store[i] = 8'h00;

    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(HEADER_BYTE, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(HEADER_BYTE, 1'b0);
    send_word(HEADER_BYTE, 1'b0);
    send_word(8'd4, 1'b0);
    send_record(8'd1, 8'hFF, 8'h00);
    send_record(8'd0, 8'h12, 8'h34);
    send_record(8'd33, 8'hA5, 8'h5A);
    send_record(8'd1, 8'hFF, 8'h00);
    send_word(8'hA5, 1'b0);
    send_word(HEADER_BYTE, 1'b1);
    send_word(8'd1, 1'b0);
    send_record(8'd32, 8'h00, 8'hFF);
    send_word(8'h00, 1'b0);

    fed = tx_bytes.size();
    first_frame = 1'b1;
    while (fed < RANDOM_BYTES) begin
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          noise = 8'($urandom_range(0, 255));
          if (noise == HEADER_BYTE) noise ^= 8'h01;
          send_word(noise, 1'b0);
        end
        fed += n;
      end else if (kind == 1) begin
        n = $urandom_range(0, 4);
        send_word(HEADER_BYTE, 1'b0);
        send_word(8'($urandom_range(1, 4)), 1'b0);
        repeat (n) send_word(8'($urandom_range(0, 255)), 1'b0);
        fed += n + 2;
      end else begin
        count = ($urandom_range(0, 24) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        send_word(HEADER_BYTE, first_frame || $urandom_range(0, 11) == 0);
        send_word(8'(count), 1'b0);
        first_frame = 1'b0;
        repeat (count) begin
          kind = $urandom_range(0, 9);
          if (kind == 0) begin
            send_record(8'd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
          end else if (kind == 1) begin
            send_record(8'($urandom_range(33, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
          end else begin
            m = $urandom_range(1, STORE_BYTES / 2);
            send_record(8'(m), pick_byte((m - 1) * 2 + 1), pick_byte((m - 1) * 2));
          end
        end
        send_word(8'($urandom_range(0, 255)), 1'b0);
        fed += 3 + 3 * count;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (tx_bytes.size() != 0) @(posedge clk);
    while (pending_changes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("fed %0d bytes: %0d frames, %0d records (%0d skipped)",
             bytes_fed, frames_seen, records_done, records_skipped);
    $display("checked %0d contact events, %0d mismatches", events_checked, errors);
    if (errors == 0 && pending_changes.size() == 0) begin
      $display("feedback_frame_change_detector_core verification clean");
    end else begin
      $display("feedback_frame_change_detector_core verification failed");
    end
    $finish;
  end

endmodule

// ----- feedback_frame_change_detector_core.f -----
rtl/ffcd_pkg.sv
rtl/ffcd_ctrl.sv
rtl/ffcd_datapath.sv
rtl/feedback_frame_change_detector_core.sv
rtl/ffcd_checker.sv
sim/feedback_frame_change_detector_core_test.sv
